FILE: src/script_token_lexer_core_macros.svh
// assertion macros of the lexer core
`ifndef SCRIPT_TOKEN_LEXER_CORE_MACROS_SVH
`define SCRIPT_TOKEN_LEXER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// check that holds in the same cycle as its condition
`define STL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lexer core check failed");
// check that holds in the cycle after its condition
`define STL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lexer core check failed");
`else
`define STL_ASSERT_NOW(lbl, ante, cons)
`define STL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/stl_pkg.sv
// types, token codes and keyword table of the lexer core
package stl_pkg;

  // token kinds
  localparam logic [4:0] K_INT     = 5'd0;
  localparam logic [4:0] K_IDENT   = 5'd1;
  localparam logic [4:0] K_KW_BASE = 5'd2;
  localparam logic [4:0] K_LPAREN  = 5'd16;
  localparam logic [4:0] K_RPAREN  = 5'd17;
  localparam logic [4:0] K_COMMA   = 5'd18;
  localparam logic [4:0] K_ASSIGN  = 5'd19;
  localparam logic [4:0] K_EQ      = 5'd20;
  localparam logic [4:0] K_NE      = 5'd21;
  localparam logic [4:0] K_LT      = 5'd22;
  localparam logic [4:0] K_LE      = 5'd23;
  localparam logic [4:0] K_GT      = 5'd24;
  localparam logic [4:0] K_GE      = 5'd25;
  localparam logic [4:0] K_PLUS    = 5'd26;
  localparam logic [4:0] K_MINUS   = 5'd27;
  localparam logic [4:0] K_STAR    = 5'd28;
  localparam logic [4:0] K_SLASH   = 5'd29;
  localparam logic [4:0] K_PERCENT = 5'd30;
  localparam logic [4:0] K_EOF     = 5'd31;

  // error codes
  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_OVERFLOW = 3'd1;
  localparam logic [2:0] E_BANG     = 3'd2;
  localparam logic [2:0] E_CHAR     = 3'd3;
  localparam logic [2:0] E_LONG     = 3'd4;

  // saturation limits of line and column, and the integer overflow limit
  localparam logic [19:0] LINE_MAX = 20'hFFFFF;
  localparam logic [15:0] COL_MAX  = 16'hFFFF;
  localparam logic [62:0] INT_MAX  = {63{1'b1}};

  localparam int NUM_KW = 14;

  // one single-result token
  typedef struct packed {
    logic [4:0]  kind;
    logic [2:0]  err;
    logic [62:0] val;
    logic [19:0] line;
    logic [15:0] col;
  } tok_t;

  function automatic tok_t mk_tok(input logic [4:0] kind, input logic [2:0] err,
                                  input logic [62:0] val, input logic [19:0] line,
                                  input logic [15:0] col);
    tok_t t;
    t.kind = kind;
    t.err  = err;
    t.val  = val;
    t.line = line;
    t.col  = col;
    return t;
  endfunction

  // keyword text, left aligned in six bytes
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] p);
    logic [47:0] s;
    case (k)
      4'd0:    s = {"if", 32'h0};
      4'd1:    s = {"then", 16'h0};
      4'd2:    s = {"else", 16'h0};
      4'd3:    s = {"end", 24'h0};
      4'd4:    s = {"while", 8'h0};
      4'd5:    s = {"do", 32'h0};
      4'd6:    s = "repeat";
      4'd7:    s = {"func", 16'h0};
      4'd8:    s = "return";
      4'd9:    s = {"true", 16'h0};
      4'd10:   s = {"false", 8'h0};
      4'd11:   s = {"and", 24'h0};
      4'd12:   s = {"or", 32'h0};
      4'd13:   s = {"not", 24'h0};
      default: s = '0;
    endcase
    return (p > 3'd5) ? 8'h00 : s[8*(3'd5 - p) +: 8];
  endfunction

  function automatic logic [2:0] kw_len(input logic [3:0] k);
    logic [2:0] l;
    case (k)
      4'd0, 4'd5, 4'd12:          l = 3'd2;
      4'd3, 4'd11, 4'd13:         l = 3'd3;
      4'd1, 4'd2, 4'd7, 4'd9:     l = 3'd4;
      4'd4, 4'd10:                l = 3'd5;
      4'd6, 4'd8:                 l = 3'd6;
      default:                    l = 3'd0;
    endcase
    return l;
  endfunction

endpackage

FILE: src/stl_ram.sv
// simple dual-port ram with registered read
module stl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: src/script_token_lexer_core.sv
// streaming lexer core: byte requests in, token result requests out
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------------------------------
//   in      | in_valid_i / in_stall_o | ch_i, has_char_i, end_of_source_i
//   out     | out_valid_o/ out_stall_i| kind_o .. last_o (results of each request)
//
// one input request per cycle while each gives at most one result and out flows
// a request that ends an identifier holds the input while the text run drains
// from the buffer ram, one byte per cycle while out flows
// one request gives up to three single tokens, or two and a text run
// reset clears the lexer state; a stalled result holds the input until the
// last result of its request loads into the output register
`include "script_token_lexer_core_macros.svh"

module script_token_lexer_core
  import stl_pkg::*;
#(
  parameter int MAX_IDENT_LEN = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        has_char_i,
  input  logic        end_of_source_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  kind_o,
  output logic [2:0]  error_code_o,
  output logic [62:0] int_value_o,
  output logic [19:0] line_no_o,
  output logic [15:0] col_no_o,
  output logic        has_text_o,
  output logic [7:0]  text_byte_o,
  output logic [4:0]  text_pos_o,
  output logic        token_end_o,
  output logic        last_o
);

  localparam int LW = $clog2(MAX_IDENT_LEN + 1);
  localparam int IW = $clog2(MAX_IDENT_LEN);

  // lexer modes
  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_INT     = 3'd1;
  localparam logic [2:0] M_IDENT   = 3'd2;
  localparam logic [2:0] M_COMMENT = 3'd3;
  localparam logic [2:0] M_EQ      = 3'd4;
  localparam logic [2:0] M_BANG    = 3'd5;
  localparam logic [2:0] M_LT      = 3'd6;
  localparam logic [2:0] M_GT      = 3'd7;

  localparam logic [7:0] CH_LF = 8'h0A;

  // lexer state
  logic [2:0]    mode_q, mode_d;
  logic [62:0]   acc_q, acc_d;
  logic [LW-1:0] len_q, len_d;
  logic [13:0]   cand_q, cand_d;
  logic [19:0]   sl_q, sl_d, cl_q, cl_d;
  logic [15:0]   sc_q, sc_d, cc_q, cc_d;
  logic          halted_q, halted_d;

  // pending results of the last request
  logic          pend_valid_q;
  tok_t          slots_q [3];
  logic [1:0]    n_q;
  logic [1:0]    slot_ptr_q;
  logic          id_fl_q;
  logic [1:0]    id_pos_q;
  logic [LW-1:0] id_len_q, id_idx_q;
  logic [4:0]    id_kind_q;
  logic [19:0]   id_line_q;
  logic [15:0]   id_col_q;

  // results computed for the request at the input
  tok_t          slots_c [3];
  logic [1:0]    n_c;
  logic          id_fl_c;
  logic [1:0]    id_pos_c;
  logic [LW-1:0] id_len_c;
  logic [4:0]    id_kind_c;
  logic [19:0]   id_line_c;
  logic [15:0]   id_col_c;

  // buffer write and read
  logic          we_c;
  logic [IW-1:0] waddr_c, raddr;
  logic [7:0]    rdata;
  logic          byp_hit_q;
  logic [7:0]    byp_data_q;

  // sequencer
  logic          in_acc, load, id_left, id_turn, fin_pick;
  tok_t          cur_slot;

  // keyword lookup on the candidate mask
  function automatic logic [4:0] kw_match(input logic [13:0] cd, input logic [LW-1:0] ln);
    logic [4:0] kd;
    logic       found;
    kd    = K_IDENT;
    found = 1'b0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (!found && cd[k] && (ln == LW'(kw_len(4'(k))))) begin
        kd    = K_KW_BASE + 5'(k);
        found = 1'b1;
      end
    end
    return kd;
  endfunction

  // one request through the lexer
  always_comb begin : step
    logic        is_dig, is_alp, go_flush, go_idle;
    logic [66:0] prod;
    logic [4:0]  op_kind;
    mode_d   = mode_q;
    acc_d    = acc_q;
    len_d    = len_q;
    cand_d   = cand_q;
    sl_d     = sl_q;
    sc_d     = sc_q;
    cl_d     = cl_q;
    cc_d     = cc_q;
    halted_d = halted_q;
    for (int i = 0; i < 3; i++) begin
      slots_c[i] = '0;
    end
    n_c       = 2'd0;
    id_fl_c   = 1'b0;
    id_pos_c  = 2'd0;
    id_len_c  = len_q;
    id_kind_c = K_IDENT;
    id_line_c = sl_q;
    id_col_c  = sc_q;
    we_c      = 1'b0;
    waddr_c   = '0;
    go_flush  = 1'b0;
    go_idle   = 1'b0;
    op_kind   = K_EQ;
    is_dig    = (ch_i >= "0") && (ch_i <= "9");
    is_alp    = ((ch_i >= "a") && (ch_i <= "z")) || ((ch_i >= "A") && (ch_i <= "Z"))
                || (ch_i == "_");
    prod      = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {63'd0, ch_i[3:0]};

    if (has_char_i && !halted_d) begin
      // continue the token in progress
      case (mode_d)
        M_INT: begin
          if (is_dig) begin
            if (prod > {4'd0, INT_MAX}) begin
              slots_c[n_c] = mk_tok(K_INT, E_OVERFLOW, '0, sl_d, sc_d);
              n_c = n_c + 2'd1;
              halted_d = 1'b1;
              mode_d = M_IDLE;
            end else begin
              acc_d = prod[62:0];
            end
          end else begin
            go_flush = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alp || is_dig) begin
            if (len_d >= LW'(MAX_IDENT_LEN)) begin
              slots_c[n_c] = mk_tok(K_INT, E_LONG, '0, sl_d, sc_d);
              n_c = n_c + 2'd1;
              halted_d = 1'b1;
              mode_d = M_IDLE;
            end else begin
              we_c = 1'b1;
              waddr_c = len_d[IW-1:0];
              for (int k = 0; k < NUM_KW; k++) begin
                cand_d[k] = cand_d[k] && (len_d < LW'(kw_len(4'(k))))
                            && (kw_char(4'(k), len_d[2:0]) == ch_i);
              end
              len_d = len_d + LW'(1);
            end
          end else begin
            go_flush = 1'b1;
          end
        end
        M_COMMENT: begin
          if (ch_i == CH_LF) begin
            mode_d = M_IDLE;
          end
        end
        M_EQ, M_BANG, M_LT, M_GT: begin
          if (ch_i == "=") begin
            case (mode_d)
              M_EQ:    op_kind = K_EQ;
              M_BANG:  op_kind = K_NE;
              M_LT:    op_kind = K_LE;
              default: op_kind = K_GE;
            endcase
            slots_c[n_c] = mk_tok(op_kind, E_NONE, '0, sl_d, sc_d);
            n_c = n_c + 2'd1;
            mode_d = M_IDLE;
          end else if (mode_d == M_BANG) begin
            slots_c[n_c] = mk_tok(K_INT, E_BANG, '0, sl_d, sc_d);
            n_c = n_c + 2'd1;
            halted_d = 1'b1;
            mode_d = M_IDLE;
          end else begin
            go_flush = 1'b1;
          end
        end
        default: go_flush = 1'b1;
      endcase

      // close the token held by the mode
      if (go_flush) begin
        case (mode_d)
          M_INT: begin
            slots_c[n_c] = mk_tok(K_INT, E_NONE, acc_d, sl_d, sc_d);
            n_c = n_c + 2'd1;
          end
          M_IDENT: begin
            id_fl_c   = 1'b1;
            id_pos_c  = n_c;
            id_len_c  = len_d;
            id_kind_c = kw_match(cand_d, len_d);
            id_line_c = sl_d;
            id_col_c  = sc_d;
            len_d     = '0;
          end
          M_EQ: begin
            slots_c[n_c] = mk_tok(K_ASSIGN, E_NONE, '0, sl_d, sc_d);
            n_c = n_c + 2'd1;
          end
          M_LT: begin
            slots_c[n_c] = mk_tok(K_LT, E_NONE, '0, sl_d, sc_d);
            n_c = n_c + 2'd1;
          end
          M_GT: begin
            slots_c[n_c] = mk_tok(K_GT, E_NONE, '0, sl_d, sc_d);
            n_c = n_c + 2'd1;
          end
          default: ;
        endcase
        mode_d  = M_IDLE;
        go_idle = !halted_d;
      end

      // start a new token from idle
      if (go_idle) begin
        if ((ch_i == " ") || (ch_i == 8'h09) || (ch_i == 8'h0D) || (ch_i == CH_LF)) begin
          mode_d = M_IDLE;
        end else if (ch_i == "#") begin
          mode_d = M_COMMENT;
        end else if (is_dig) begin
          sl_d   = cl_q;
          sc_d   = cc_q;
          acc_d  = {59'd0, ch_i[3:0]};
          mode_d = M_INT;
        end else if (is_alp) begin
          sl_d    = cl_q;
          sc_d    = cc_q;
          we_c    = 1'b1;
          waddr_c = '0;
          for (int k = 0; k < NUM_KW; k++) begin
            cand_d[k] = (kw_char(4'(k), 3'd0) == ch_i);
          end
          len_d  = LW'(1);
          mode_d = M_IDENT;
        end else begin
          case (ch_i)
            "(", ")", ",", "+", "-", "*", "/", "%": begin
              case (ch_i)
                "(":     op_kind = K_LPAREN;
                ")":     op_kind = K_RPAREN;
                ",":     op_kind = K_COMMA;
                "+":     op_kind = K_PLUS;
                "-":     op_kind = K_MINUS;
                "*":     op_kind = K_STAR;
                "/":     op_kind = K_SLASH;
                default: op_kind = K_PERCENT;
              endcase
              slots_c[n_c] = mk_tok(op_kind, E_NONE, '0, cl_q, cc_q);
              n_c = n_c + 2'd1;
            end
            "=", "!", "<", ">": begin
              case (ch_i)
                "=":     mode_d = M_EQ;
                "!":     mode_d = M_BANG;
                "<":     mode_d = M_LT;
                default: mode_d = M_GT;
              endcase
              sl_d = cl_q;
              sc_d = cc_q;
            end
            default: begin
              slots_c[n_c] = mk_tok(K_INT, E_CHAR, '0, cl_q, cc_q);
              n_c = n_c + 2'd1;
              halted_d = 1'b1;
              mode_d = M_IDLE;
            end
          endcase
        end
      end

      // position update, saturating
      if (ch_i == CH_LF) begin
        if (cl_d != LINE_MAX) begin
          cl_d = cl_d + 20'd1;
        end
        cc_d = 16'd1;
      end else if (cc_d != COL_MAX) begin
        cc_d = cc_d + 16'd1;
      end
    end

    // end of source: unless halted, close the open token and, if no error arose, add end of input; restart
    if (end_of_source_i) begin
      if (!halted_d) begin
        case (mode_d)
          M_INT: begin
            slots_c[n_c] = mk_tok(K_INT, E_NONE, acc_d, sl_d, sc_d);
            n_c = n_c + 2'd1;
          end
          M_IDENT: begin
            id_fl_c   = 1'b1;
            id_pos_c  = n_c;
            id_len_c  = len_d;
            id_kind_c = kw_match(cand_d, len_d);
            id_line_c = sl_d;
            id_col_c  = sc_d;
          end
          M_EQ: begin
            slots_c[n_c] = mk_tok(K_ASSIGN, E_NONE, '0, sl_d, sc_d);
            n_c = n_c + 2'd1;
          end
          M_LT: begin
            slots_c[n_c] = mk_tok(K_LT, E_NONE, '0, sl_d, sc_d);
            n_c = n_c + 2'd1;
          end
          M_GT: begin
            slots_c[n_c] = mk_tok(K_GT, E_NONE, '0, sl_d, sc_d);
            n_c = n_c + 2'd1;
          end
          M_BANG: begin
            slots_c[n_c] = mk_tok(K_INT, E_BANG, '0, sl_d, sc_d);
            n_c = n_c + 2'd1;
            halted_d = 1'b1;
          end
          default: ;
        endcase
        if (!halted_d) begin
          slots_c[n_c] = mk_tok(K_EOF, E_NONE, '0, cl_d, cc_d);
          n_c = n_c + 2'd1;
        end
      end
      mode_d   = M_IDLE;
      acc_d    = '0;
      len_d    = '0;
      sl_d     = 20'd1;
      sc_d     = 16'd1;
      cl_d     = 20'd1;
      cc_d     = 16'd1;
      halted_d = 1'b0;
    end
  end

  // output sequencing over the pending results
  assign id_left  = id_fl_q && (id_idx_q != id_len_q);
  assign id_turn  = id_left && (slot_ptr_q == id_pos_q);
  assign cur_slot = (slot_ptr_q == 2'd2) ? slots_q[2] :
                    (slot_ptr_q == 2'd1) ? slots_q[1] : slots_q[0];
  assign fin_pick = id_turn ? (((id_idx_q + LW'(1)) == id_len_q) && (slot_ptr_q == n_q))
                            : (((slot_ptr_q + 2'd1) == n_q) && !id_left);
  assign load       = pend_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = pend_valid_q && !(load && fin_pick);
  assign in_acc     = in_valid_i && !in_stall_o;

  // read ahead so the next text byte is ready when its turn comes
  always_comb begin
    if (in_acc && id_fl_c) begin
      raddr = '0;
    end else if (load && id_turn) begin
      raddr = IW'(id_idx_q + LW'(1));
    end else begin
      raddr = IW'(id_idx_q);
    end
  end

  // identifier text buffer
  stl_ram #(
    .WIDTH (8),
    .DEPTH (MAX_IDENT_LEN)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && we_c),
    .waddr_i (waddr_c),
    .wdata_i (ch_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // bypass for a read of the byte written in the same cycle
  always_ff @(posedge clk_i) begin
    byp_hit_q  <= in_acc && we_c && (waddr_c == raddr);
    byp_data_q <= ch_i;
  end

  // lexer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      acc_q    <= '0;
      len_q    <= '0;
      cand_q   <= '0;
      sl_q     <= 20'd1;
      sc_q     <= 16'd1;
      cl_q     <= 20'd1;
      cc_q     <= 16'd1;
      halted_q <= 1'b0;
    end else if (in_acc) begin
      mode_q   <= mode_d;
      acc_q    <= acc_d;
      len_q    <= len_d;
      cand_q   <= cand_d;
      sl_q     <= sl_d;
      sc_q     <= sc_d;
      cl_q     <= cl_d;
      cc_q     <= cc_d;
      halted_q <= halted_d;
    end
  end

  // pending result control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      slot_ptr_q   <= 2'd0;
      id_idx_q     <= '0;
      n_q          <= 2'd0;
      id_fl_q      <= 1'b0;
      id_pos_q     <= 2'd0;
      id_len_q     <= '0;
    end else begin
      if (load) begin
        if (fin_pick) begin
          pend_valid_q <= 1'b0;
        end else if (id_turn) begin
          id_idx_q <= id_idx_q + LW'(1);
        end else begin
          slot_ptr_q <= slot_ptr_q + 2'd1;
        end
      end
      if (in_acc && ((n_c != 2'd0) || id_fl_c)) begin
        pend_valid_q <= 1'b1;
        slot_ptr_q   <= 2'd0;
        id_idx_q     <= '0;
        n_q          <= n_c;
        id_fl_q      <= id_fl_c;
        id_pos_q     <= id_pos_c;
        id_len_q     <= id_len_c;
      end
    end
  end

  // pending result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      slots_q   <= slots_c;
      id_kind_q <= id_kind_c;
      id_line_q <= id_line_c;
      id_col_q  <= id_col_c;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      last_o <= fin_pick;
      if (id_turn) begin
        kind_o       <= id_kind_q;
        error_code_o <= E_NONE;
        int_value_o  <= '0;
        line_no_o    <= id_line_q;
        col_no_o     <= id_col_q;
        has_text_o   <= 1'b1;
        text_byte_o  <= byp_hit_q ? byp_data_q : rdata;
        text_pos_o   <= 5'(id_idx_q);
        token_end_o  <= (id_idx_q + LW'(1)) == id_len_q;
      end else begin
        kind_o       <= cur_slot.kind;
        error_code_o <= cur_slot.err;
        int_value_o  <= cur_slot.val;
        line_no_o    <= cur_slot.line;
        col_no_o     <= cur_slot.col;
        has_text_o   <= 1'b0;
        text_byte_o  <= 8'h00;
        text_pos_o   <= 5'd0;
        token_end_o  <= 1'b1;
      end
    end
  end

  `STL_ASSERT_NOW(a_idle_no_stall, !pend_valid_q, !in_stall_o)
  `STL_ASSERT_NOW(a_text_idx_range, pend_valid_q, id_idx_q <= id_len_q)
  `STL_ASSERT_NOW(a_slot_ptr_range, pend_valid_q, slot_ptr_q <= n_q)
  `STL_ASSERT_NEXT(a_source_restart, in_acc && end_of_source_i, !halted_q && (mode_q == M_IDLE))

endmodule
